// ----- sv/sobel_pkg.sv -----
// Shared constants and the Sobel arithmetic for the edge magnitude block.
// No dependencies; imported by sobel_edge_magnitude.
package sobel_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 10;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_W      = 11;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAG_MAX    = 255;

    // register indexes of the configuration port
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // |Gx| + |Gy| over a 3x3 window, clamped to 8 bits.
    // t*, m*, b* are top, middle and bottom rows; a = left, b = center, d = right.
    function automatic pix_t sobel_mag(input pix_t ta, input pix_t tb, input pix_t td,
                                       input pix_t ma, input pix_t md,
                                       input pix_t ba, input pix_t bb, input pix_t bd);
        logic [9:0]         x_pos;
        logic [9:0]         x_neg;
        logic [9:0]         y_pos;
        logic [9:0]         y_neg;
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic [10:0]        ax;
        logic [10:0]        ay;
        logic [11:0]        mag;
        x_pos = {2'b00, td} + {1'b0, md, 1'b0} + {2'b00, bd};
        x_neg = {2'b00, ta} + {1'b0, ma, 1'b0} + {2'b00, ba};
        y_pos = {2'b00, ta} + {1'b0, tb, 1'b0} + {2'b00, td};
        y_neg = {2'b00, ba} + {1'b0, bb, 1'b0} + {2'b00, bd};
        gx = signed'({1'b0, x_pos}) - signed'({1'b0, x_neg});
        gy = signed'({1'b0, y_pos}) - signed'({1'b0, y_neg});
        ax = gx[10] ? 11'(-gx) : 11'(gx);
        ay = gy[10] ? 11'(-gy) : 11'(gy);
        mag = {1'b0, ax} + {1'b0, ay};
        sobel_mag = (mag > 12'(MAG_MAX)) ? pix_t'(MAG_MAX) : mag[PIX_W-1:0];
    endfunction

endpackage

// ----- sv/sobel_edge_magnitude.sv -----
// 3x3 Sobel edge magnitude on a raster pixel stream, with two line-store memories.
// Depends on sobel_pkg.
//
// Pixels enter in raster order, one beat per clock while s_ready is high. Each
// accepted pixel at (r,c) yields up to three result beats: the window centre
// (r-1,c-1) once r and c are nonzero, the right-border pixel (r-1,width-1) at the
// end of a row, and the border pixel (r,c) itself in the last row. Border results
// are zero. An input beat is registered into the compute stage, and its results
// then into the single output register, which moves one result a clock unless
// output back-pressure holds it; a pixel keeps the compute stage until all of its
// results have left. The line stores are synchronous memories read when a pixel
// is accepted and written back when it leaves the compute stage; a same-address
// bypass covers a read and a write landing in the same clock.
// Configure frame_width and frame_height only while no beat is in flight;
// out-of-range sizes are clamped (0 to 1, above MAX_WIDTH or 1024 to that
// maximum). No clearing pass is needed.
module sobel_edge_magnitude import sobel_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_edge_value,
    output logic [ROW_W-1:0]     m_out_row,
    output logic [OUT_COL_W-1:0] m_out_col,
    output logic                 m_frame_last
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int ROWC_W    = ROW_W + 1;

    // configuration, stored already clamped
    logic [CNT_W-1:0]  width_reg;
    logic [ROWC_W-1:0] height_reg;

    // input position counters
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;

    // compute stage
    logic              s1_valid_reg;
    logic [2:0]        s1_pend_reg;
    logic [2:0]        s1_last_reg;
    logic              s1_inner_reg;
    pix_t              s1_pixel_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;

    // line stores and their read data
    pix_t              prev_mem  [MAX_WIDTH];
    pix_t              prev2_mem [MAX_WIDTH];
    pix_t              prev_q_reg;
    pix_t              prev2_q_reg;
    logic              byp_reg;
    pix_t              byp_prev_reg;
    pix_t              byp_prev2_reg;

    // 3x3 window: [0],[1] top row, [2],[3] middle row, [4],[5] bottom row
    pix_t              win_reg [6];

    // output register
    logic              m_valid_reg;
    pix_t              m_edge_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [OUT_COL_W-1:0] m_col_reg;
    logic              m_last_reg;

    // stage-0 combinational position and flags
    logic              accept;
    logic [CNT_W-1:0]  col_ext;
    logic              wrap_col;
    logic [COL_W-1:0]  c0;
    logic [CNT_W-1:0]  c0_ext;
    logic [CNT_W-1:0]  c0_inc;
    logic [ROWC_W-1:0] r_pre;
    logic [ROW_W-1:0]  r0;
    logic [ROWC_W-1:0] r0_ext;
    logic [ROWC_W-1:0] r0_inc;
    logic              last_col;
    logic [2:0]        pend_new;
    logic [2:0]        last_new;
    logic              inner_new;

    // stage-1 combinational
    pix_t              md;
    pix_t              td;
    pix_t              mag;
    logic              out_free;
    logic              emit;
    logic              retire;
    logic [2:0]        pick;
    logic [2:0]        pend_after;
    pix_t              res_edge;
    logic [ROW_W-1:0]  res_row;
    logic [COL_W-1:0]  res_col;
    logic              res_last;

    assign accept = s_valid && s_ready;

    // configuration writes, clamped to the legal range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CNT_W'(WIDTH_RST);
            height_reg <= ROWC_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (cfg_wr_data == '0) begin
                        width_reg <= CNT_W'(1);
                    end else if (int'(cfg_wr_data) > MAX_WIDTH) begin
                        width_reg <= CNT_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= CNT_W'(cfg_wr_data);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (cfg_wr_data == '0) begin
                        height_reg <= ROWC_W'(1);
                    end else if (int'(cfg_wr_data) > MAX_HEIGHT) begin
                        height_reg <= ROWC_W'(MAX_HEIGHT);
                    end else begin
                        height_reg <= ROWC_W'(cfg_wr_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // position of the incoming beat, wrapping if the size shrank
    always_comb begin
        col_ext  = CNT_W'(col_reg);
        wrap_col = (col_ext >= width_reg);
        c0       = wrap_col ? '0 : col_reg;
        r_pre    = wrap_col ? ({1'b0, row_reg} + ROWC_W'(1)) : {1'b0, row_reg};
        r0       = (r_pre >= height_reg) ? '0 : r_pre[ROW_W-1:0];
        c0_ext   = CNT_W'(c0);
        r0_ext   = {1'b0, r0};
        c0_inc   = c0_ext + CNT_W'(1);
        r0_inc   = r0_ext + ROWC_W'(1);

        if (c0_inc >= width_reg) begin
            col_next = '0;
            row_next = (r0_inc >= height_reg) ? '0 : r0_inc[ROW_W-1:0];
        end else begin
            col_next = COL_W'(c0_inc);
            row_next = r0;
        end

        last_col    = (c0_ext == width_reg - CNT_W'(1));
        pend_new[0] = (r0 != '0) && (c0 != '0);
        pend_new[1] = (r0 != '0) && last_col;
        pend_new[2] = (r0_ext == height_reg - ROWC_W'(1));
        // centre (r-1,c-1) is inside unless it touches an edge
        inner_new   = (r0 != ROW_W'(1)) && (c0 != COL_W'(1)) &&
                      (r0_ext != height_reg) && (c0_ext != width_reg);
        last_new[0] = (r0_ext == height_reg) && (c0_ext == width_reg);
        last_new[1] = (r0_ext == height_reg);
        last_new[2] = last_col;
    end

    // advance the position on each input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store read on accept, with bypass of a write in the same clock
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_q_reg  <= prev_mem[c0];
            prev2_q_reg <= prev2_mem[c0];
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            prev_mem[s1_col_reg]  <= s1_pixel_reg;
            prev2_mem[s1_col_reg] <= md;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (accept) begin
            byp_reg <= retire && (s1_col_reg == c0);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byp_prev_reg  <= s1_pixel_reg;
            byp_prev2_reg <= md;
        end
    end

    assign md = byp_reg ? byp_prev_reg  : prev_q_reg;
    assign td = byp_reg ? byp_prev2_reg : prev2_q_reg;

    // compute stage: pick the lowest pending result and hand it to the output
    always_comb begin
        mag        = sobel_mag(win_reg[0], win_reg[1], td, win_reg[2], md,
                               win_reg[4], win_reg[5], s1_pixel_reg);
        out_free   = !m_valid_reg || m_ready;
        emit       = s1_valid_reg && (s1_pend_reg != '0) && out_free;
        pick       = s1_pend_reg & (~s1_pend_reg + 3'd1);
        pend_after = s1_pend_reg & ~pick;
        retire     = s1_valid_reg && ((s1_pend_reg == '0) || (emit && pend_after == '0));

        res_edge = '0;
        res_row  = s1_row_reg - ROW_W'(1);
        res_col  = s1_col_reg;
        res_last = s1_last_reg[2];
        case (pick)
            3'b001: begin
                res_edge = s1_inner_reg ? mag : '0;
                res_col  = s1_col_reg - COL_W'(1);
                res_last = s1_last_reg[0];
            end
            3'b010: begin
                res_last = s1_last_reg[1];
            end
            default: begin
                res_row  = s1_row_reg;
            end
        endcase
    end

    assign s_ready = !s1_valid_reg || retire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            s1_pend_reg  <= pend_new;
        end else if (retire) begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
        end else if (emit) begin
            s1_pend_reg  <= pend_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= s_pixel;
            s1_row_reg   <= r0;
            s1_col_reg   <= c0;
            s1_inner_reg <= inner_new;
            s1_last_reg  <= last_new;
        end
    end

    // shift the window when a beat leaves the compute stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (retire) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= td;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= md;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pixel_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_edge_reg <= res_edge;
            m_row_reg  <= res_row;
            m_col_reg  <= OUT_COL_W'(res_col);
            m_last_reg <= res_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_value = m_edge_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_frame_last = m_last_reg;

    // pending results only exist for a live beat in the compute stage
    a_pend_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_pend_reg != '0) |-> s1_valid_reg)
        else $error("pending results without a beat in the compute stage");

    // an emitted result lands in the output register
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("emitted result not held in output register");

    // column counter stays inside the line store
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(col_reg) < MAX_WIDTH))
        else $error("column counter beyond line store depth");

    // the frame-last result is the bottom-right pixel
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |->
            ((m_row_reg == ROW_W'(height_reg - ROWC_W'(1))) &&
             (m_col_reg == OUT_COL_W'(width_reg - CNT_W'(1)))))
        else $error("frame-last flag away from the bottom-right pixel");

    // left-column results are border zeros
    a_left_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_col_reg == '0)) |-> (m_edge_reg == '0))
        else $error("nonzero result on the left border");

endmodule
